>>> rtl/kafa_pkg.sv
// ============================================================================
// kafa_pkg
// Shared types and constants for the knot adhesion force accumulator.
// ============================================================================
package kafa_pkg;

    localparam int MAX_NEIGHBOURS_DEF = 64;
    localparam int FRAC_BITS_DEF      = 16;
    localparam int POS_W              = 32;
    localparam int RAD_W              = 31;
    localparam int CNT_W              = 7;

    // configuration register indexes
    localparam logic CFG_MAX_ENERGY     = 1'b0;
    localparam logic CFG_ADHESION_RATIO = 1'b1;
    localparam int   CFG_IDX_W          = 2;

    localparam logic [31:0] MAX_ENERGY_RST     = 32'd65536;
    localparam logic [31:0] ADHESION_RATIO_RST = 32'd65536;

    // input request
    typedef struct packed {
        logic signed [POS_W-1:0] cell_x;
        logic signed [POS_W-1:0] cell_y;
        logic signed [POS_W-1:0] cell_z;
        logic signed [POS_W-1:0] nbr_x;
        logic signed [POS_W-1:0] nbr_y;
        logic signed [POS_W-1:0] nbr_z;
        logic [RAD_W-1:0]        nbr_radius;
        logic                    nbr_is_knot;
        logic                    last_nbr;
    } pair_t;

    // result request
    typedef struct packed {
        logic signed [POS_W-1:0] force_x;
        logic signed [POS_W-1:0] force_y;
        logic signed [POS_W-1:0] force_z;
        logic [CNT_W-1:0]        knot_count;
    } force_t;

    // classified work handed from front to back
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic [66:0]        d2;
        logic [RAD_W-1:0]   radius;
        logic               hit;
        logic               last;
    } work_t;

    typedef struct packed {
        logic [31:0] dat;
        logic [CFG_IDX_W-1:0] idx;
    } cfg_t;

endpackage

>>> rtl/kafa_if.sv
// ============================================================================
// kafa_if
// Valid/ready channel carrying one payload of a parameterized type.
// ============================================================================
interface kafa_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/kafa_front.sv
// ============================================================================
// kafa_front
// Takes pairs, forms separation and squared distance, and classifies them.
// ============================================================================
module kafa_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kafa_pkg::pair_t in_data,
    output logic            q_valid,
    input  logic            q_ready,
    output kafa_pkg::work_t q_data
);
    import kafa_pkg::*;

    logic        st_valid_reg;
    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic [RAD_W-1:0] rad_reg;
    logic        knot_reg, last_reg;
    logic [32:0] ax, ay, az;
    logic        adv;

    // stage 1: differences
    assign adv      = !st_valid_reg || q_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else if (adv)
            st_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            dx_reg   <= 33'(in_data.cell_x) - 33'(in_data.nbr_x);
            dy_reg   <= 33'(in_data.cell_y) - 33'(in_data.nbr_y);
            dz_reg   <= 33'(in_data.cell_z) - 33'(in_data.nbr_z);
            rad_reg  <= in_data.nbr_radius;
            knot_reg <= in_data.nbr_is_knot;
            last_reg <= in_data.last_nbr;
        end
    end

    // stage 2: squares and classification
    assign ax = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign ay = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign az = dz_reg[32] ? 33'(-dz_reg) : 33'(dz_reg);

    always_comb
    begin
        q_valid       = st_valid_reg;
        q_data.dx     = dx_reg;
        q_data.dy     = dy_reg;
        q_data.dz     = dz_reg;
        q_data.d2     = 67'(ax * ax) + 67'(ay * ay) + 67'(az * az);
        q_data.radius = rad_reg;
        q_data.last   = last_reg;
        q_data.hit    = knot_reg && (ax < 33'(rad_reg)) && (ay < 33'(rad_reg))
                        && (az < 33'(rad_reg)) && (q_data.d2 != '0)
                        && (q_data.d2 < 67'(62'(rad_reg) * 62'(rad_reg)));
    end

endmodule

>>> rtl/kafa_queue.sv
// ============================================================================
// kafa_queue
// Two-entry queue decoupling the front stage from the back sequencer.
// ============================================================================
module kafa_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kafa_pkg::work_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output kafa_pkg::work_t out_data
);
    import kafa_pkg::*;

    work_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= in_data;
    end

endmodule

>>> rtl/kafa_back.sv
// ============================================================================
// kafa_back
// Sequencer: root, divides, scaling, accumulation and averaging, bit-serial.
// ============================================================================
module kafa_back #(
    parameter int MAX_NEIGHBOURS = kafa_pkg::MAX_NEIGHBOURS_DEF,
    parameter int FRAC_BITS      = kafa_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  kafa_pkg::work_t  q_data,
    input  logic [31:0]      max_energy,
    input  logic [31:0]      adhesion_ratio,
    output logic             out_valid,
    input  logic             out_ready,
    output kafa_pkg::force_t out_data
);
    import kafa_pkg::*;

    localparam int CW = $clog2(MAX_NEIGHBOURS + 1);
    localparam logic [3:0] S_IDLE = 4'd0, S_SQRT = 4'd1, S_Q1 = 4'd2, S_Q2 = 4'd3,
                           S_MAG = 4'd4, S_MUL = 4'd5, S_CMP = 4'd6, S_ACC = 4'd7,
                           S_AVG = 4'd8, S_OUT = 4'd9, S_SCL = 4'd10;
    // energy * |t| at or above this no longer fits a signed 32-bit magnitude
    localparam logic [95:0] MAG_LIM = 96'd1 << (31 + FRAC_BITS);

    logic [3:0]  st_reg;
    logic [6:0]  it_reg;
    logic [1:0]  ax_reg;          // axis index for component/avg loops
    logic [66:0] rem_reg;         // sqrt remainder / divider remainder
    logic [66:0] num_reg;         // dividend shift register
    logic [33:0] root_reg;
    logic [66:0] quo_reg;
    logic [66:0] q1_reg;
    logic signed [32:0] d_reg [3];
    logic [RAD_W-1:0] rad_reg;
    logic        last_reg;
    logic signed [31:0] mag_reg;
    logic signed [47:0] sum_reg [3];
    logic [CW-1:0] cnt_reg;
    logic signed [31:0] res_reg [3];
    logic [CNT_W-1:0] kc_reg;
    logic [66:0] div_reg;         // current divisor
    logic        neg_reg;
    logic [63:0] prod_lo_reg;     // energy * low word of |t|

    logic [68:0] trial;
    logic [67:0] dtrial;
    logic [66:0] tabs;
    logic        tneg;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [95:0] total;
    logic [95:0] pm;
    logic [32:0] dabs;
    logic [47:0] sabs;
    logic signed [66:0] t_full;

    assign q_ready   = (st_reg == S_IDLE);
    assign out_valid = (st_reg == S_OUT);
    assign out_data.force_x    = res_reg[0];
    assign out_data.force_y    = res_reg[1];
    assign out_data.force_z    = res_reg[2];
    assign out_data.knot_count = kc_reg;

    // one root / divide step
    assign trial  = {rem_reg, num_reg[66:65]} - {33'd0, root_reg, 2'b01};
    assign dtrial = {rem_reg, num_reg[66]} - {1'b0, div_reg};
    assign t_full = signed'(q1_reg) - signed'(quo_reg);
    assign tneg   = t_full[66];
    assign tabs   = tneg ? 67'(-t_full) : 67'(t_full);
    // one 32x32 multiplier, low word of |t| first, high word next cycle
    assign mul_b  = (st_reg == S_MAG) ? tabs[31:0] : tabs[63:32];
    assign prod   = 64'(max_energy) * 64'(mul_b);
    assign total  = 96'(prod_lo_reg) + {prod, 32'd0};
    assign pm     = total >> FRAC_BITS;
    assign dabs   = d_reg[ax_reg][32] ? 33'(-d_reg[ax_reg]) : 33'(d_reg[ax_reg]);
    assign sabs   = sum_reg[ax_reg][47] ? 48'(-sum_reg[ax_reg]) : 48'(sum_reg[ax_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        d_reg[0] <= q_data.dx;
                        d_reg[1] <= q_data.dy;
                        d_reg[2] <= q_data.dz;
                        rad_reg  <= q_data.radius;
                        last_reg <= q_data.last;
                        rem_reg  <= '0;
                        root_reg <= '0;
                        // d2 < 2^62 for a hit: its low 64 bits go to the top
                        num_reg  <= q_data.d2 << 3;
                        it_reg   <= '0;
                        if (q_data.hit && (cnt_reg < CW'(MAX_NEIGHBOURS)))
                            st_reg <= S_SQRT;
                        else if (q_data.last)
                        begin
                            st_reg <= S_AVG;
                            ax_reg <= 2'd0;
                        end
                    end
                end
                // restoring root, two bits per step over 32 steps
                S_SQRT:
                begin
                    num_reg <= num_reg << 2;
                    if (!trial[68])
                    begin
                        rem_reg  <= 67'(trial);
                        root_reg <= {root_reg[32:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= {rem_reg[64:0], num_reg[66:65]};
                        root_reg <= {root_reg[32:0], 1'b0};
                    end
                    it_reg <= it_reg + 7'd1;
                    if (it_reg == 7'd31)
                    begin
                        st_reg  <= S_Q1;
                        it_reg  <= '0;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        num_reg <= 67'(adhesion_ratio) << FRAC_BITS;
                    end
                end
                // shared restoring divider: q1 then q2, 67 steps each
                S_Q1, S_Q2:
                begin
                    if (it_reg == 7'd0 && st_reg == S_Q1)
                        div_reg <= 67'(root_reg);
                    if (it_reg == 7'd0 && st_reg == S_Q2)
                        div_reg <= 67'(rad_reg);
                    if (it_reg != 7'd0)
                    begin
                        num_reg <= num_reg << 1;
                        if (!dtrial[67])
                        begin
                            rem_reg <= 67'(dtrial);
                            quo_reg <= {quo_reg[65:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[65:0], num_reg[66]};
                            quo_reg <= {quo_reg[65:0], 1'b0};
                        end
                    end
                    it_reg <= it_reg + 7'd1;
                    if (it_reg == 7'd67)
                    begin
                        it_reg <= '0;
                        if (st_reg == S_Q1)
                        begin
                            st_reg  <= S_Q2;
                            q1_reg  <= {quo_reg[65:0], !dtrial[67]};
                            rem_reg <= '0;
                            quo_reg <= '0;
                            num_reg <= 67'(1) << (2 * FRAC_BITS);
                        end
                        else
                        begin
                            st_reg  <= S_MAG;
                            quo_reg <= {quo_reg[65:0], !dtrial[67]};
                        end
                    end
                end
                // magnitude: low partial product
                S_MAG:
                begin
                    st_reg      <= S_SCL;
                    neg_reg     <= tneg;
                    prod_lo_reg <= prod;
                    ax_reg      <= 2'd0;
                end
                // magnitude: high partial product, scale and saturate
                S_SCL:
                begin
                    st_reg <= S_MUL;
                    if (max_energy != 0 && (tabs[66:64] != '0 || total >= MAG_LIM))
                        mag_reg <= tneg ? 32'sh80000000 : 32'sh7fffffff;
                    else
                        mag_reg <= tneg ? 32'(-signed'(pm[31:0]))
                                        : signed'(pm[31:0]);
                end
                // component: |d|*|mag| then divide by s
                S_MUL:
                begin
                    rem_reg <= '0;
                    quo_reg <= '0;
                    num_reg <= 67'(64'(dabs) * 64'($unsigned(mag_reg[31] ? -mag_reg
                                                                        : mag_reg)))
                               << 1;
                    div_reg <= 67'(root_reg);
                    neg_reg <= d_reg[ax_reg][32] ^ mag_reg[31];
                    it_reg  <= '0;
                    st_reg  <= S_CMP;
                end
                S_CMP:
                begin
                    num_reg <= num_reg << 1;
                    if (!dtrial[67])
                    begin
                        rem_reg <= 67'(dtrial);
                        quo_reg <= {quo_reg[65:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[65:0], num_reg[66]};
                        quo_reg <= {quo_reg[65:0], 1'b0};
                    end
                    it_reg <= it_reg + 7'd1;
                    if (it_reg == 7'd65)
                        st_reg <= S_ACC;
                end
                S_ACC:
                begin
                    sum_reg[ax_reg] <= sum_reg[ax_reg]
                        + (neg_reg ? 48'(-quo_reg[47:0]) : quo_reg[47:0]);
                    if (ax_reg == 2'd2)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        if (last_reg)
                        begin
                            st_reg <= S_AVG;
                            ax_reg <= 2'd0;
                            it_reg <= '0;
                        end
                        else
                            st_reg <= S_IDLE;
                    end
                    else
                    begin
                        ax_reg <= ax_reg + 2'd1;
                        st_reg <= S_MUL;
                    end
                end
                // average: |sum| / count, 48 bit steps per axis
                S_AVG:
                begin
                    if (it_reg == 7'd0)
                    begin
                        rem_reg <= '0;
                        quo_reg <= '0;
                        num_reg <= 67'(sabs) << 19;
                        div_reg <= 67'(cnt_reg);
                        neg_reg <= sum_reg[ax_reg][47];
                        it_reg  <= 7'd1;
                    end
                    else if (it_reg <= 7'd48)
                    begin
                        num_reg <= num_reg << 1;
                        if (!dtrial[67])
                        begin
                            rem_reg <= 67'(dtrial);
                            quo_reg <= {quo_reg[65:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[65:0], num_reg[66]};
                            quo_reg <= {quo_reg[65:0], 1'b0};
                        end
                        it_reg <= it_reg + 7'd1;
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                            res_reg[ax_reg] <= '0;
                        else if (!neg_reg && quo_reg > 67'h7fffffff)
                            res_reg[ax_reg] <= 32'sh7fffffff;
                        else if (neg_reg && quo_reg > 67'h80000000)
                            res_reg[ax_reg] <= 32'sh80000000;
                        else
                            res_reg[ax_reg] <= neg_reg ? 32'(-quo_reg[31:0])
                                                       : quo_reg[31:0];
                        it_reg <= '0;
                        if (ax_reg == 2'd2)
                        begin
                            st_reg <= S_OUT;
                            kc_reg <= CNT_W'(cnt_reg);
                            cnt_reg <= '0;
                            for (int i = 0; i < 3; i++)
                                sum_reg[i] <= '0;
                        end
                        else
                            ax_reg <= ax_reg + 2'd1;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                        st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/knot_adhesion_force_accumulator_core.sv
// ============================================================================
// knot_adhesion_force_accumulator_core
// Averages knot adhesion forces over a run of neighbour pairs.
// ============================================================================
// channel   | dir | payload
// pair      | in  | cell xyz, nbr xyz, radius, knot flag, last flag
// result    | out | force xyz, knot_count
// cfg       | in  | register index, write data
//
// A pair is taken by a two-stage front each cycle while the queue has room.
// Non-interacting pairs are consumed by the back in its idle state; an
// interacting knot runs a 32-step root, two 67-step divides, two scaling
// states and three 66-step divides.
// A last pair adds an averaging divide per axis before the result shows.
// Reset clears sums, count and registers to their defaults; either side may
// stall freely.
module knot_adhesion_force_accumulator_core #(
    parameter int MAX_NEIGHBOURS = kafa_pkg::MAX_NEIGHBOURS_DEF,
    parameter int FRAC_BITS      = kafa_pkg::FRAC_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    kafa_if.sink   pair,
    kafa_if.source result,
    kafa_if.sink   cfg
);
    import kafa_pkg::*;

    logic [31:0] max_energy_reg, adhesion_ratio_reg;
    logic  fq_valid, fq_ready, qb_valid, qb_ready;
    work_t fq_data, qb_data;

    // configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_energy_reg     <= MAX_ENERGY_RST;
            adhesion_ratio_reg <= ADHESION_RATIO_RST;
        end
        else if (cfg.valid && cfg.data.idx[1] == 1'b0)
        begin
            if (cfg.data.idx[0] == CFG_MAX_ENERGY)
                max_energy_reg <= cfg.data.dat;
            else
                adhesion_ratio_reg <= cfg.data.dat;
        end
    end

    kafa_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(pair.valid), .in_ready(pair.ready), .in_data(pair.data),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    kafa_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
    );

    kafa_back #(.MAX_NEIGHBOURS(MAX_NEIGHBOURS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
        .max_energy(max_energy_reg), .adhesion_ratio(adhesion_ratio_reg),
        .out_valid(result.valid), .out_ready(result.ready), .out_data(result.data)
    );

endmodule
